// ----- rtl/core/opd_pkg.sv -----
// Shared types and codes for the OpenPGP packet deframer.
package opd_pkg;

    typedef enum logic [2:0] {
        PH_TAG       = 3'd0,
        PH_OLD_LEN   = 3'd1,
        PH_NEW_FIRST = 3'd2,
        PH_NEW_MORE  = 3'd3,
        PH_BODY      = 3'd4,
        PH_INDET     = 3'd5
    } phase_t;

    typedef logic [1:0] role_t;
    localparam role_t ROLE_TAG    = 2'd0;
    localparam role_t ROLE_LENGTH = 2'd1;
    localparam role_t ROLE_BODY   = 2'd2;
    localparam role_t ROLE_REJECT = 2'd3;

    typedef logic [2:0] len_kind_t;
    localparam len_kind_t LK_ONE     = 3'd0;
    localparam len_kind_t LK_TWO     = 3'd1;
    localparam len_kind_t LK_FOUR    = 3'd2;
    localparam len_kind_t LK_FIVE    = 3'd3;
    localparam len_kind_t LK_PARTIAL = 3'd4;
    localparam len_kind_t LK_INDET   = 3'd5;

    typedef logic [2:0] seg_event_t;
    localparam seg_event_t EV_NONE   = 3'd0;
    localparam seg_event_t EV_WHOLE  = 3'd1;
    localparam seg_event_t EV_FIRST  = 3'd2;
    localparam seg_event_t EV_MIDDLE = 3'd3;
    localparam seg_event_t EV_FINAL  = 3'd4;

    typedef logic [1:0] err_t;
    localparam err_t ERR_NONE    = 2'd0;
    localparam err_t ERR_BAD_TAG = 2'd1;
    localparam err_t ERR_EARLY   = 2'd2;

    localparam logic [15:0] CHUNK_RESET  = 16'd8192;
    localparam logic [7:0]  TWO_OCT_LOW  = 8'hc0;
    localparam logic [7:0]  PARTIAL_LOW  = 8'he0;
    localparam logic [7:0]  FIVE_OCT_TAG = 8'hff;
    localparam logic [31:0] TWO_OCT_BIAS = 32'd192;

endpackage

// ----- rtl/core/openpgp_packet_deframer.sv -----
// OpenPGP packet deframer: tags each stream byte as tag, length octet, body or rejected.
// A result is loaded into the output register on the clock edge that accepts its byte.
// Throughput: one byte per cycle; the only stage is the result register, and a new byte
// is taken whenever that register is empty or is being emptied in the same cycle.
// Reset (rst_n low, asynchronous) returns the parser to expecting a tag, clears the
// sticky error and the output valid, and sets the chunk size register to 8192.
module openpgp_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] indeterminate_chunk,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,

    output logic        out_valid,
    input  logic        out_ready,
    output opd_pkg::role_t      byte_role,
    output logic [7:0]          data_out,
    output logic [5:0]          packet_kind,
    output logic                new_format,
    output opd_pkg::len_kind_t  length_kind,
    output logic                length_ready,
    output logic [31:0]         segment_length,
    output opd_pkg::seg_event_t segment_event,
    output opd_pkg::err_t       error_code
);
    import opd_pkg::*;

    // Configuration: the chunk size used to cut indeterminate-length bodies, always writable.
    // The user must send writes only while the block is idle; the block does not enforce it.
    logic [15:0] chunk_reg;
    logic [15:0] chunk_size;

    // Parser state, updated once per accepted byte.
    phase_t      phase_reg,        phase_next;
    logic [5:0]  type_reg,         type_next;
    logic        format_reg,       format_next;
    len_kind_t   kind_reg,         kind_next;
    logic [31:0] acc_reg,          acc_next;
    logic [2:0]  octets_left_reg,  octets_left_next;
    logic [31:0] remaining_reg,    remaining_next;
    logic        started_reg,      started_next;
    logic        partial_reg,      partial_next;
    err_t        sticky_error_reg, sticky_error_next;

    // Result register; the payload carries no reset, only the valid flag does.
    logic        out_valid_reg;
    role_t       role_reg;
    logic [7:0]  data_reg;
    logic [5:0]  kind_out_reg;
    logic        format_out_reg;
    len_kind_t   lkind_out_reg;
    logic        ready_out_reg;
    logic [31:0] seglen_out_reg;
    seg_event_t  event_out_reg;
    err_t        error_out_reg;

    // Values computed for the byte at the input.
    role_t       role_next;
    logic        ready_next;
    logic [31:0] seglen_next;
    seg_event_t  event_next;

    logic        accept;

    assign cfg_ready  = 1'b1;
    assign chunk_size = (chunk_reg == 16'd0) ? 16'd1 : chunk_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // The whole per-byte decision. A completed length and the end of a counted
    // segment are flagged inside the case and resolved afterwards, so that both
    // see the updated partial flag just as the header rules require.
    always_comb
    begin
        logic        len_done;
        logic [31:0] len_val;
        logic        seg_end;
        logic [31:0] acc_inc;

        len_done = 1'b0;
        len_val  = 32'd0;
        seg_end  = 1'b0;
        acc_inc  = acc_reg + 32'd1;

        phase_next        = phase_reg;
        type_next         = type_reg;
        format_next       = format_reg;
        kind_next         = kind_reg;
        acc_next          = acc_reg;
        octets_left_next  = octets_left_reg;
        remaining_next    = remaining_reg;
        started_next      = started_reg;
        partial_next      = partial_reg;
        sticky_error_next = sticky_error_reg;

        role_next   = ROLE_TAG;
        ready_next  = 1'b0;
        seglen_next = 32'd0;
        event_next  = EV_NONE;

        // A byte without bit 7 where a tag belongs poisons the stream.
        if (sticky_error_reg == ERR_NONE && phase_reg == PH_TAG && !data_byte[7])
        begin
            sticky_error_next = ERR_BAD_TAG;
        end

        if (sticky_error_next != ERR_NONE)
        begin
            // Rejected byte: only the data and the error code carry information.
            role_next = ROLE_REJECT;
        end
        else
        begin
            case (phase_reg)
                PH_OLD_LEN, PH_NEW_MORE:
                begin
                    role_next = ROLE_LENGTH;
                    if (phase_reg == PH_NEW_MORE && kind_reg == LK_TWO)
                    begin
                        acc_next         = acc_reg + {24'd0, data_byte} + TWO_OCT_BIAS;
                        octets_left_next = 3'd0;
                    end
                    else
                    begin
                        acc_next         = {acc_reg[23:0], data_byte};
                        octets_left_next = octets_left_reg - 3'd1;
                    end
                    if (octets_left_next == 3'd0)
                    begin
                        ready_next  = 1'b1;
                        seglen_next = acc_next;
                        len_done    = 1'b1;
                        len_val     = acc_next;
                    end
                end
                PH_NEW_FIRST:
                begin
                    role_next = ROLE_LENGTH;
                    if (data_byte < TWO_OCT_LOW)
                    begin
                        kind_next    = LK_ONE;
                        partial_next = 1'b0;
                        ready_next   = 1'b1;
                        seglen_next  = {24'd0, data_byte};
                        len_done     = 1'b1;
                        len_val      = {24'd0, data_byte};
                    end
                    else if (data_byte < PARTIAL_LOW)
                    begin
                        kind_next        = LK_TWO;
                        partial_next     = 1'b0;
                        acc_next         = {19'd0, data_byte[4:0] , 8'd0};
                        octets_left_next = 3'd1;
                        phase_next       = PH_NEW_MORE;
                    end
                    else if (data_byte != FIVE_OCT_TAG)
                    begin
                        kind_next    = LK_PARTIAL;
                        partial_next = 1'b1;
                        ready_next   = 1'b1;
                        seglen_next  = 32'd1 << data_byte[4:0];
                        len_done     = 1'b1;
                        len_val      = 32'd1 << data_byte[4:0];
                    end
                    else
                    begin
                        kind_next        = LK_FIVE;
                        partial_next     = 1'b0;
                        acc_next         = 32'd0;
                        octets_left_next = 3'd4;
                        phase_next       = PH_NEW_MORE;
                    end
                end
                PH_BODY:
                begin
                    role_next      = ROLE_BODY;
                    seglen_next    = acc_reg;
                    remaining_next = remaining_reg - 32'd1;
                    seg_end        = (remaining_next == 32'd0);
                end
                PH_INDET:
                begin
                    role_next   = ROLE_BODY;
                    acc_next    = acc_inc;
                    seglen_next = {16'd0, chunk_size};
                    if (end_of_stream)
                    begin
                        event_next  = started_reg ? EV_FINAL : EV_WHOLE;
                        seglen_next = acc_inc;
                        phase_next  = PH_TAG;
                    end
                    else if (acc_inc >= {16'd0, chunk_size})
                    begin
                        event_next   = started_reg ? EV_MIDDLE : EV_FIRST;
                        started_next = 1'b1;
                        acc_next     = 32'd0;
                    end
                end
                default:
                begin
                    // Tag byte: start a fresh packet.
                    role_next      = ROLE_TAG;
                    started_next   = 1'b0;
                    partial_next   = 1'b0;
                    acc_next       = 32'd0;
                    remaining_next = 32'd0;
                    if (data_byte[6])
                    begin
                        format_next = 1'b1;
                        type_next   = data_byte[5:0];
                        kind_next   = LK_ONE;
                        phase_next  = PH_NEW_FIRST;
                    end
                    else
                    begin
                        format_next = 1'b0;
                        type_next   = {2'd0, data_byte[5:2]};
                        case (data_byte[1:0])
                            2'd0:
                            begin
                                kind_next        = LK_ONE;
                                octets_left_next = 3'd1;
                                phase_next       = PH_OLD_LEN;
                            end
                            2'd1:
                            begin
                                kind_next        = LK_TWO;
                                octets_left_next = 3'd2;
                                phase_next       = PH_OLD_LEN;
                            end
                            2'd2:
                            begin
                                kind_next        = LK_FOUR;
                                octets_left_next = 3'd4;
                                phase_next       = PH_OLD_LEN;
                            end
                            default:
                            begin
                                // Indeterminate body, cut into chunks until end of stream.
                                kind_next    = LK_INDET;
                                partial_next = 1'b1;
                                ready_next   = 1'b1;
                                seglen_next  = {16'd0, chunk_size};
                                phase_next   = PH_INDET;
                                if (end_of_stream)
                                begin
                                    event_next  = EV_WHOLE;
                                    seglen_next = 32'd0;
                                    phase_next  = PH_TAG;
                                end
                            end
                        endcase
                    end
                end
            endcase

            if (len_done)
            begin
                acc_next         = len_val;
                remaining_next   = len_val;
                octets_left_next = 3'd0;
                if (len_val == 32'd0)
                begin
                    seg_end = 1'b1;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end

            // A counted segment ended: report which part it was.
            if (seg_end)
            begin
                if (!started_next)
                begin
                    event_next = partial_next ? EV_FIRST : EV_WHOLE;
                end
                else
                begin
                    event_next = partial_next ? EV_MIDDLE : EV_FINAL;
                end
                started_next = 1'b1;
                phase_next   = partial_next ? PH_NEW_FIRST : PH_TAG;
            end

            // The stream stopped with a packet still open.
            if (end_of_stream && phase_next != PH_TAG)
            begin
                sticky_error_next = ERR_EARLY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            chunk_reg <= indeterminate_chunk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TAG;
            type_reg         <= 6'd0;
            format_reg       <= 1'b0;
            kind_reg         <= LK_ONE;
            acc_reg          <= 32'd0;
            octets_left_reg  <= 3'd0;
            remaining_reg    <= 32'd0;
            started_reg      <= 1'b0;
            partial_reg      <= 1'b0;
            sticky_error_reg <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            type_reg         <= type_next;
            format_reg       <= format_next;
            kind_reg         <= kind_next;
            acc_reg          <= acc_next;
            octets_left_reg  <= octets_left_next;
            remaining_reg    <= remaining_next;
            started_reg      <= started_next;
            partial_reg      <= partial_next;
            sticky_error_reg <= sticky_error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // A rejected byte reports zeros in every field except the role, the data and the error.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            role_reg       <= role_next;
            data_reg       <= data_byte;
            error_out_reg  <= sticky_error_next;
            if (role_next == ROLE_REJECT)
            begin
                kind_out_reg   <= 6'd0;
                format_out_reg <= 1'b0;
                lkind_out_reg  <= LK_ONE;
                ready_out_reg  <= 1'b0;
                seglen_out_reg <= 32'd0;
                event_out_reg  <= EV_NONE;
            end
            else
            begin
                kind_out_reg   <= type_next;
                format_out_reg <= format_next;
                lkind_out_reg  <= kind_next;
                ready_out_reg  <= ready_next;
                seglen_out_reg <= seglen_next;
                event_out_reg  <= event_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_role      = role_reg;
    assign data_out       = data_reg;
    assign packet_kind    = kind_out_reg;
    assign new_format     = format_out_reg;
    assign length_kind    = lkind_out_reg;
    assign length_ready   = ready_out_reg;
    assign segment_length = seglen_out_reg;
    assign segment_event  = event_out_reg;
    assign error_code     = error_out_reg;

    // Once an error is recorded it never changes until reset.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sticky_error_reg != ERR_NONE |=> sticky_error_reg == $past(sticky_error_reg))
        else $error("sticky error changed");

    // While old-format length octets are pending, the count is never zero.
    a_octets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OLD_LEN |-> octets_left_reg != 3'd0)
        else $error("old-format length phase with no octets left");

    // A rejected byte always carries an error code, and any error but an early end always rejects.
    a_reject_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((role_reg == ROLE_REJECT) == (error_out_reg != ERR_NONE)
                           || error_out_reg == ERR_EARLY))
        else $error("rejected role and error code disagree");

    // A length is only ever completed by a tag or a length octet.
    a_ready_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ready_out_reg |-> role_reg == ROLE_TAG || role_reg == ROLE_LENGTH)
        else $error("length completed on a body byte");

    // Body phases are only entered after the byte that closed a header.
    a_body_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == PH_BODY) |-> $past(accept)
                                        && ($past(role_next) == ROLE_LENGTH))
        else $error("body phase entered without a length octet");

endmodule

// ----- test/tb_openpgp_packet_deframer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the OpenPGP packet deframer with its own byte-level predictor.
module tb_openpgp_packet_deframer;

    import opd_pkg::*;

    // The run is cut off here if the block stops making progress.
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Tag prefixes and the old-format length form that means "indeterminate".
    localparam logic [1:0] OLD_TAG_PREFIX = 2'b10;
    localparam logic [1:0] NEW_TAG_PREFIX = 2'b11;
    localparam logic [1:0] OLD_INDET_FORM = 2'b11;

    // One stream byte waiting to be driven.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    // One tagged byte as the block reports it.
    typedef struct packed {
        role_t      role;
        logic [7:0] data;
        logic [5:0] kind;
        logic       new_fmt;
        len_kind_t  lkind;
        logic       len_ready;
        logic [31:0] seg_len;
        seg_event_t seg_ev;
        err_t       err;
    } tagged_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] chunk_wdata = 16'd0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        end_of_stream = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    role_t       byte_role;
    logic [7:0]  data_out;
    logic [5:0]  packet_kind;
    logic        new_format;
    len_kind_t   length_kind;
    logic        length_ready;
    logic [31:0] segment_length;
    seg_event_t  segment_event;
    err_t        error_code;

    // Bytes still to be driven, and the tagged bytes the block still owes us.
    stream_byte_t stream_bytes[$];
    tagged_byte_t tagged_due[$];
    stream_byte_t next_byte;
    tagged_byte_t want_byte;

    int unsigned cycles = 0;
    int unsigned bytes_queued = 0;
    int unsigned mismatches = 0;

    // Parser state of the predictor. The block is reset only once, at the start,
    // so the declaration values stand in for the reset values.
    phase_t      parse_phase = PH_TAG;
    logic [5:0]  pkt_type = 6'd0;
    logic        pkt_new = 1'b0;
    len_kind_t   pkt_lkind = LK_ONE;
    logic [31:0] len_acc = 32'd0;
    logic [2:0]  len_left = 3'd0;
    logic [31:0] body_left = 32'd0;
    logic        pkt_started = 1'b0;
    logic        in_partial = 1'b0;
    err_t        sticky_err = ERR_NONE;
    logic [15:0] chunk_cfg = CHUNK_RESET;

    openpgp_packet_deframer DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .indeterminate_chunk (chunk_wdata),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .end_of_stream       (end_of_stream),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .byte_role           (byte_role),
        .data_out            (data_out),
        .packet_kind         (packet_kind),
        .new_format          (new_format),
        .length_kind         (length_kind),
        .length_ready        (length_ready),
        .segment_length      (segment_length),
        .segment_event       (segment_event),
        .error_code          (error_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A counted segment has run out. A partial segment hands control back to
    // the next length part, anything else ends the packet.
    function automatic seg_event_t close_segment();
        seg_event_t ev;
        if (!pkt_started)
        begin
            ev = in_partial ? EV_FIRST : EV_WHOLE;
            pkt_started = 1'b1;
        end
        else
        begin
            ev = in_partial ? EV_MIDDLE : EV_FINAL;
        end
        if (in_partial)
            parse_phase = PH_NEW_FIRST;
        else
            parse_phase = PH_TAG;
        return ev;
    endfunction

    // A segment length has been fully decoded. A zero length closes the
    // segment on the spot, so its event lands on the length octet.
    function automatic seg_event_t length_complete(input logic [31:0] len);
        len_acc = len;
        body_left = len;
        len_left = 3'd0;
        if (len == 32'd0)
            return close_segment();
        parse_phase = PH_BODY;
        return EV_NONE;
    endfunction

    // Works out the tagged byte that one accepted stream byte must produce.
    function automatic tagged_byte_t deframe_byte(input logic [7:0] b, input logic eos);
        tagged_byte_t r;
        logic [31:0]  chunk_now;
        r = '0;
        r.data = b;
        // A chunk register of zero behaves as a chunk of one byte.
        chunk_now = (chunk_cfg == 16'd0) ? 32'd1 : {16'd0, chunk_cfg};

        // A byte without bit 7 where a tag belongs poisons the stream for good.
        if (sticky_err == ERR_NONE && parse_phase == PH_TAG && !b[7])
            sticky_err = ERR_BAD_TAG;
        if (sticky_err != ERR_NONE)
        begin
            r.role = ROLE_REJECT;
            r.err = sticky_err;
            return r;
        end

        case (parse_phase)
            PH_OLD_LEN, PH_NEW_MORE:
            begin
                r.role = ROLE_LENGTH;
                if (parse_phase == PH_NEW_MORE && pkt_lkind == LK_TWO)
                begin
                    len_acc = len_acc + b + TWO_OCT_BIAS;
                    len_left = 3'd0;
                end
                else
                begin
                    len_acc = {len_acc[23:0], b};
                    len_left = len_left - 3'd1;
                end
                if (len_left == 3'd0)
                begin
                    r.len_ready = 1'b1;
                    r.seg_len = len_acc;
                    r.seg_ev = length_complete(len_acc);
                end
            end
            PH_NEW_FIRST:
            begin
                r.role = ROLE_LENGTH;
                if (b < TWO_OCT_LOW)
                begin
                    pkt_lkind = LK_ONE;
                    in_partial = 1'b0;
                    r.len_ready = 1'b1;
                    r.seg_len = {24'd0, b};
                    r.seg_ev = length_complete({24'd0, b});
                end
                else if (b < PARTIAL_LOW)
                begin
                    pkt_lkind = LK_TWO;
                    in_partial = 1'b0;
                    len_acc = {19'd0, b[4:0], 8'd0};
                    len_left = 3'd1;
                    parse_phase = PH_NEW_MORE;
                end
                else if (b < FIVE_OCT_TAG)
                begin
                    pkt_lkind = LK_PARTIAL;
                    in_partial = 1'b1;
                    r.len_ready = 1'b1;
                    r.seg_len = 32'd1 << b[4:0];
                    r.seg_ev = length_complete(r.seg_len);
                end
                else
                begin
                    pkt_lkind = LK_FIVE;
                    in_partial = 1'b0;
                    len_acc = 32'd0;
                    len_left = 3'd4;
                    parse_phase = PH_NEW_MORE;
                end
            end
            PH_BODY:
            begin
                r.role = ROLE_BODY;
                r.seg_len = len_acc;
                body_left = body_left - 32'd1;
                if (body_left == 32'd0)
                    r.seg_ev = close_segment();
            end
            PH_INDET:
            begin
                // Indeterminate bodies are counted in chunks; end of stream wins
                // over a chunk that fills on the same byte.
                r.role = ROLE_BODY;
                len_acc = len_acc + 32'd1;
                r.seg_len = chunk_now;
                if (eos)
                begin
                    r.seg_ev = pkt_started ? EV_FINAL : EV_WHOLE;
                    r.seg_len = len_acc;
                    parse_phase = PH_TAG;
                end
                else if (len_acc >= chunk_now)
                begin
                    r.seg_ev = pkt_started ? EV_MIDDLE : EV_FIRST;
                    pkt_started = 1'b1;
                    len_acc = 32'd0;
                end
            end
            default:
            begin
                r.role = ROLE_TAG;
                pkt_started = 1'b0;
                in_partial = 1'b0;
                len_acc = 32'd0;
                body_left = 32'd0;
                if (b[6])
                begin
                    pkt_new = 1'b1;
                    pkt_type = b[5:0];
                    pkt_lkind = LK_ONE;
                    parse_phase = PH_NEW_FIRST;
                end
                else
                begin
                    pkt_new = 1'b0;
                    pkt_type = {2'b00, b[5:2]};
                    pkt_lkind = len_kind_t'({1'b0, b[1:0]});
                    if (b[1:0] == OLD_INDET_FORM)
                    begin
                        pkt_lkind = LK_INDET;
                        in_partial = 1'b1;
                        r.len_ready = 1'b1;
                        r.seg_len = chunk_now;
                        parse_phase = PH_INDET;
                        // An empty indeterminate body ends right on its tag.
                        if (eos)
                        begin
                            r.seg_ev = EV_WHOLE;
                            r.seg_len = 32'd0;
                            parse_phase = PH_TAG;
                        end
                    end
                    else
                    begin
                        if (pkt_lkind == LK_ONE)
                            len_left = 3'd1;
                        else if (pkt_lkind == LK_TWO)
                            len_left = 3'd2;
                        else
                            len_left = 3'd4;
                        parse_phase = PH_OLD_LEN;
                    end
                end
            end
        endcase

        // The stream may only end between packets.
        if (eos && parse_phase != PH_TAG)
            sticky_err = ERR_EARLY;

        r.kind = pkt_type;
        r.new_fmt = pkt_new;
        r.lkind = pkt_lkind;
        r.err = sticky_err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] v, input logic last);
        stream_byte_t s;
        s.value = v;
        s.last = last;
        stream_bytes.push_back(s);
        bytes_queued++;
    endtask

    // Random body bytes; the last one optionally closes the stream.
    task automatic push_body(input int unsigned n, input logic eos_at_end);
        for (int unsigned i = 0; i < n; i++)
            push_byte(8'($urandom), eos_at_end && (i == n - 1));
    endtask

    // Old-format packet with a 1-, 2- or 4-octet big-endian length.
    task automatic put_old_format(input logic [3:0] ptype, input len_kind_t lk,
                                  input logic [31:0] len, input logic eos_end);
        int n;
        n = (lk == LK_ONE) ? 1 : (lk == LK_TWO) ? 2 : 4;
        push_byte({OLD_TAG_PREFIX, ptype, lk[1:0]}, 1'b0);
        for (int i = n - 1; i >= 0; i--)
            push_byte(len[8 * i +: 8], eos_end && (len == 32'd0) && (i == 0));
        push_body(len, eos_end);
    endtask

    // New-format length in one-, two- or five-octet form.
    task automatic new_length(input len_kind_t lk, input logic [31:0] len,
                              input logic eos_here);
        logic [31:0] biased;
        biased = len - TWO_OCT_BIAS;
        if (lk == LK_ONE)
        begin
            push_byte(len[7:0], eos_here);
        end
        else if (lk == LK_TWO)
        begin
            push_byte(TWO_OCT_LOW + biased[15:8], 1'b0);
            push_byte(biased[7:0], eos_here);
        end
        else
        begin
            push_byte(FIVE_OCT_TAG, 1'b0);
            for (int i = 3; i >= 0; i--)
                push_byte(len[8 * i +: 8], eos_here && (i == 0));
        end
    endtask

    // New-format packet: some short partial parts, then a final length part.
    task automatic put_new_format(input logic [5:0] ptype, input int parts,
                                  input len_kind_t lk, input logic [31:0] len,
                                  input logic eos_end);
        logic [4:0] expo;
        push_byte({NEW_TAG_PREFIX, ptype}, 1'b0);
        repeat (parts)
        begin
            expo = 5'($urandom_range(4));
            push_byte(PARTIAL_LOW | {3'd0, expo}, 1'b0);
            push_body(32'd1 << expo, 1'b0);
        end
        new_length(lk, len, eos_end && (len == 32'd0));
        push_body(len, eos_end);
    endtask

    // Old-format packet of indeterminate length; it always ends the stream.
    task automatic indet_packet(input logic [3:0] ptype, input int unsigned n);
        push_byte({OLD_TAG_PREFIX, ptype, OLD_INDET_FORM}, n == 0);
        push_body(n, 1'b1);
    endtask

    function automatic int unsigned short_len();
        return ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
    endfunction

    // One well-formed packet of random shape and content.
    task automatic random_packet();
        int unsigned pick;
        logic        eos_end;
        len_kind_t   lk;
        pick = $urandom_range(99);
        eos_end = ($urandom_range(7) == 0);
        if (pick < 35)
        begin
            case ($urandom_range(2))
                0: lk = LK_ONE;
                1: lk = LK_TWO;
                default: lk = LK_FOUR;
            endcase
            put_old_format(4'($urandom), lk, short_len(), eos_end);
        end
        else if (pick < 82)
        begin
            if ($urandom_range(9) == 0)
                put_new_format(6'($urandom), $urandom_range(1), LK_TWO,
                               TWO_OCT_BIAS + $urandom_range(60), eos_end);
            else
                put_new_format(6'($urandom),
                               ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3),
                               ($urandom_range(3) == 0) ? LK_FIVE : LK_ONE,
                               short_len(), eos_end);
        end
        else
        begin
            indet_packet(4'($urandom), $urandom_range(12));
        end
    endtask

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------

    // Random idling on both sides, except during one calm stretch.
    function automatic bit take_break();
        bit calm;
        calm = (cycles >= 600) && (cycles < 1100);
        return !calm && ($urandom_range(99) < 35);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Waits until every queued byte is in and every tagged byte is out.
    task automatic drain_all();
        while (stream_bytes.size() != 0 || in_valid || tagged_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes the chunk size register while the parser is idle.
    task automatic write_chunk(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        chunk_wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        chunk_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued bytes and predicts each one as it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                tagged_due.push_back(deframe_byte(data_byte, end_of_stream));
            // A new item may only go up once the current one has been taken.
            if (!in_valid || in_ready)
            begin
                if (stream_bytes.size() != 0 && !take_break())
                begin
                    next_byte = stream_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_byte.value;
                    end_of_stream <= next_byte.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each tagged byte with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tagged_due.size() == 0)
                begin
                    $error("unexpected tagged byte, data_out %0h", data_out);
                    mismatches++;
                end
                else
                begin
                    want_byte = tagged_due.pop_front();
                    check_field("byte_role", want_byte.role, byte_role);
                    check_field("data_out", want_byte.data, data_out);
                    check_field("packet_kind", want_byte.kind, packet_kind);
                    check_field("new_format", want_byte.new_fmt, new_format);
                    check_field("length_kind", want_byte.lkind, length_kind);
                    check_field("length_ready", want_byte.len_ready, length_ready);
                    check_field("segment_length", want_byte.seg_len, segment_length);
                    check_field("segment_event", want_byte.seg_ev, segment_event);
                    check_field("error_code", want_byte.err, error_code);
                end
            end
            out_ready <= !take_break();
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[openpgp_packet_deframer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned goal;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed packets at the reset chunk size: every length form but the new-format
        // two-octet one, type extremes, zero-length segments, partial parts and an
        // empty indeterminate body.
        put_old_format(4'h0, LK_ONE, 32'd0, 1'b0);
        put_old_format(4'hf, LK_TWO, 32'd2, 1'b0);
        put_old_format(4'h5, LK_FOUR, 32'd1, 1'b0);
        put_new_format(6'h00, 0, LK_ONE, 32'd1, 1'b0);
        put_new_format(6'h11, 0, LK_ONE, 32'd0, 1'b0);
        // Partial parts ending in a zero-length final part, closing the stream.
        put_new_format(6'h3f, 2, LK_FIVE, 32'd0, 1'b1);
        indet_packet(4'h9, 0);
        indet_packet(4'h3, 3);
        drain_all();

        // A zero chunk register acts as one byte: first, middle and final
        // chunks, then a chunk that fills on the last byte of the stream.
        write_chunk(16'd0);
        indet_packet(4'h6, 3);
        indet_packet(4'ha, 1);
        drain_all();

        // Random streams under several chunk sizes.
        for (int phase_no = 0; phase_no < 4; phase_no++)
        begin
            case (phase_no)
                0: write_chunk(16'hffff);
                1: write_chunk(16'd1);
                default: write_chunk(16'($urandom_range(2, 8)));
            endcase
            goal = bytes_queued + 130;
            while (bytes_queued < goal)
                random_packet();
            drain_all();
        end

        // The stream is broken at the very end, since errors hold until reset:
        // a bad tag, or an end of stream inside a packet with a huge length.
        case ($urandom_range(4))
            0:
            begin
                push_byte(8'($urandom_range(127)), 1'($urandom_range(1)));
            end
            1:
            begin
                push_byte({OLD_TAG_PREFIX, 4'($urandom), LK_FOUR[1:0]}, 1'b0);
                repeat (4) push_byte(8'hff, 1'b0);
                push_body(3, 1'b1);
            end
            2:
            begin
                push_byte({NEW_TAG_PREFIX, 6'($urandom)}, 1'b0);
                push_byte(FIVE_OCT_TAG, 1'b0);
                repeat (4) push_byte(8'hff, 1'b0);
                push_body(2, 1'b1);
            end
            3:
            begin
                // Largest two-octet length, cut short by the end of the stream.
                push_byte({NEW_TAG_PREFIX, 6'($urandom)}, 1'b0);
                push_byte(PARTIAL_LOW - 8'd1, 1'b0);
                push_byte(8'hff, 1'b0);
                push_body(4, 1'b1);
            end
            default:
            begin
                // Largest partial length, cut short by the end of the stream.
                push_byte({NEW_TAG_PREFIX, 6'($urandom)}, 1'b0);
                push_byte(FIVE_OCT_TAG - 8'd1, 1'b0);
                push_body(5, 1'b1);
            end
        endcase
        // Everything after the error must come back rejected.
        repeat (20) push_byte(8'($urandom), 1'($urandom_range(1)));
        drain_all();
        repeat (5) @(posedge clk);

        if (mismatches == 0)
            $display("[openpgp_packet_deframer] OK");
        else
            $display("[openpgp_packet_deframer] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/opd_pkg.sv
rtl/core/openpgp_packet_deframer.sv
test/tb_openpgp_packet_deframer.sv
